/* hdl/alid_pkg.sv */
`default_nettype none

package alid_pkg;

	// Defaults for the top-level parameters.
	localparam int DEPTH_DEF  = 128;
	localparam int ELEM_W_DEF = 32;

	// Fixed payload widths of the two channels.
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int LEN_W = 8;

	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_DELETE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} stat_t;

	// Request from the controller to the shift walker.
	typedef struct packed {
		logic start;
		logic up;
	} walk_cmd_t;

	// Walker status back to the controller.
	typedef struct packed {
		logic busy;
		logic last_wr;
	} walk_sts_t;

endpackage

`default_nettype wire

/* hdl/alid_if.sv */
`default_nettype none

// Command channel.
interface alid_in_if import alid_pkg::*; ();
	logic               valid;
	logic               ready;
	cmd_t               cmd;
	logic [POS_W-1:0]   position;
	logic [VAL_W-1:0]   value;

	modport source (output valid, output cmd, output position, output value, input ready);
	modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

// Result channel.
interface alid_out_if import alid_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VAL_W-1:0]   read_value;
	stat_t              status;
	logic [POS_W-1:0]   first_position;
	logic [LEN_W-1:0]   list_length;
	logic               is_empty;

	modport source (output valid, output read_value, output status, output first_position,
		output list_length, output is_empty, input ready);
	modport sink   (input valid, input read_value, input status, input first_position,
		input list_length, input is_empty, output ready);
endinterface

`default_nettype wire

/* hdl/alid_ram.sv */
`default_nettype none

module alid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hdl/alid_walk.sv */
`default_nettype none

// Moves a run of entries by one place. Each cycle one entry is read and the
// entry read in the cycle before is written to its new place, so the read and
// write addresses never meet. One incrementer/decrementer steps the read
// address and one comparator detects the end of the run.
module alid_walk import alid_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire walk_cmd_t     cmd,
	input  wire logic [AW-1:0] rd_start,
	input  wire logic [AW-1:0] wr_start,
	input  wire logic [AW-1:0] stop,
	output logic      [AW-1:0] raddr,
	output logic               we,
	output logic      [AW-1:0] waddr,
	output walk_sts_t          sts
);

	logic          active_q;
	logic          vld_s1;
	logic          up_q;
	logic [AW-1:0] rd_q;
	logic [AW-1:0] tgt_q;
	logic [AW-1:0] tgt_s1;
	logic [AW-1:0] stop_q;
	logic [AW-1:0] rd_nxt;

	assign rd_nxt = rd_q + (up_q ? AW'(1) : {AW{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= active_q;
			if (cmd.start) begin
				active_q <= 1'b1;
			end else if (active_q && rd_q == stop_q) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tgt_s1 <= tgt_q;
		if (cmd.start) begin
			rd_q   <= rd_start;
			tgt_q  <= wr_start;
			stop_q <= stop;
			up_q   <= cmd.up;
		end else if (active_q) begin
			// The entry just read lands where the previous read came from.
			rd_q  <= rd_nxt;
			tgt_q <= rd_q;
		end
	end

	assign raddr       = rd_q;
	assign we          = vld_s1;
	assign waddr       = tgt_s1;
	assign sts.busy    = active_q | vld_s1;
	assign sts.last_wr = vld_s1 & ~active_q;

endmodule

`default_nettype wire

/* hdl/array_list_insert_delete_unit.sv */
`default_nettype none

// Channel   Port  Role    Transaction carries
// --------  ----  ------  ---------------------------------------------------------
// command   req   sink    cmd, position, value
// result    rsp   source  read_value, status, first_position, list_length, is_empty
//
// A write or a rejected command goes straight to its result, a read first waits
// for the store, and an insert or delete that moves entries first runs the shift
// walk, an insert then writing its value. The walk is the slowest part:
// the store has one write port, so one entry moves per cycle.
// Reset clears the list shape and the result slot; the element store keeps no reset value.
// A new command is taken while a result still waits on rsp; its own result
// then holds until the slot is free.
module array_list_insert_delete_unit import alid_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int ELEM_WIDTH = ELEM_W_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	alid_in_if.sink     req,
	alid_out_if.source  rsp
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	// Common width for position checks; large enough for the position field
	// and for DEPTH itself.
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDWAIT,
		S_WALK,
		S_FILL,
		S_RESP
	} state_t;

	state_t state_q;

	// List shape.
	logic [AW-1:0] first_q;
	logic [CW-1:0] count_q;
	logic          empty_q;

	// Command held across a multi-cycle operation.
	logic                  ins_q;
	logic [AW-1:0]         pos_q;
	logic [ELEM_WIDTH-1:0] val_q;
	logic [VAL_W-1:0]      rd_data_q;
	stat_t                 status_q;

	// Result slot.
	logic             out_valid_q;
	logic [VAL_W-1:0] out_rv_q;
	stat_t            out_st_q;
	logic [POS_W-1:0] out_fp_q;
	logic [LEN_W-1:0] out_len_q;
	logic             out_emp_q;

	logic accept;

	// Position checks, all in one width.
	logic [CMPW-1:0] pos_x, first_x, cnt_x, end_x, last_x, depth_x;
	logic [AW-1:0]   pos_a;
	logic            rw_ok;

	// Decoded command.
	stat_t         st_c;
	logic          do_rd, do_wr, do_walk, walk_up;
	logic [AW-1:0] nxt_first;
	logic [CW-1:0] nxt_count;
	logic          nxt_empty;
	logic [AW-1:0] walk_r0, walk_w0, walk_stop;

	// Walker and store.
	walk_cmd_t             walk_cmd;
	walk_sts_t             walk_sts;
	logic [AW-1:0]         walk_raddr, walk_waddr;
	logic                  walk_we;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [ELEM_WIDTH-1:0] ram_wdata, ram_rdata;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid & req.ready;

	assign pos_x   = CMPW'(req.position);
	assign first_x = CMPW'(first_q);
	assign cnt_x   = CMPW'(count_q);
	assign end_x   = first_x + cnt_x;
	assign last_x  = end_x - CMPW'(1);
	assign depth_x = CMPW'(DEPTH);
	assign pos_a   = AW'(req.position);
	assign rw_ok   = (pos_x >= first_x) && (pos_x < depth_x);

	always_comb begin
		st_c      = ST_OK;
		do_rd     = 1'b0;
		do_wr     = 1'b0;
		do_walk   = 1'b0;
		walk_up   = 1'b0;
		nxt_first = first_q;
		nxt_count = count_q;
		nxt_empty = empty_q;
		walk_r0   = AW'(end_x - CMPW'(1));
		walk_w0   = AW'(end_x);
		walk_stop = pos_a;
		unique case (req.cmd)
			CMD_READ: begin
				if (rw_ok) begin
					do_rd = 1'b1;
				end else begin
					st_c = ST_BADPOS;
				end
			end
			CMD_WRITE: begin
				if (rw_ok) begin
					do_wr = 1'b1;
				end else begin
					st_c = ST_BADPOS;
				end
			end
			CMD_INSERT: begin
				if (empty_q) begin
					// The first element may go anywhere in the store.
					if (pos_x < depth_x) begin
						do_wr     = 1'b1;
						nxt_first = pos_a;
						nxt_count = CW'(1);
						nxt_empty = 1'b0;
					end else begin
						st_c = ST_BADPOS;
					end
				end else if (pos_x < first_x || pos_x > end_x) begin
					st_c = ST_BADPOS;
				end else if (end_x >= depth_x) begin
					st_c = ST_FULL;
				end else begin
					nxt_count = count_q + CW'(1);
					if (pos_x == end_x) begin
						do_wr = 1'b1;
					end else begin
						// Move the tail up one place, highest entry first.
						do_walk = 1'b1;
					end
				end
			end
			CMD_DELETE: begin
				if (empty_q) begin
					st_c = ST_EMPTY;
				end else if (pos_x < first_x || pos_x > last_x) begin
					st_c = ST_BADPOS;
				end else begin
					nxt_count = count_q - CW'(1);
					if (pos_x == first_x) begin
						nxt_first = first_q + AW'(1);
					end else if (pos_x != last_x) begin
						// Move the tail down one place, lowest entry first.
						do_walk   = 1'b1;
						walk_up   = 1'b1;
						walk_r0   = AW'(pos_x + CMPW'(1));
						walk_w0   = pos_a;
						walk_stop = AW'(last_x);
					end
					if (count_q == CW'(1)) begin
						nxt_first = '0;
						nxt_empty = 1'b1;
					end
				end
			end
		endcase
	end

	assign walk_cmd.start = accept & do_walk;
	assign walk_cmd.up    = walk_up;

	alid_walk #(
		.DEPTH (DEPTH)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (walk_cmd),
		.rd_start (walk_r0),
		.wr_start (walk_w0),
		.stop     (walk_stop),
		.raddr    (walk_raddr),
		.we       (walk_we),
		.waddr    (walk_waddr),
		.sts      (walk_sts)
	);

	// The walker owns the store during a shift; otherwise the command does.
	assign ram_raddr = (state_q == S_WALK) ? walk_raddr : pos_a;
	assign ram_we    = walk_we | (accept & do_wr) | (state_q == S_FILL);
	always_comb begin
		if (walk_we) begin
			ram_waddr = walk_waddr;
			ram_wdata = ram_rdata;
		end else if (state_q == S_FILL) begin
			ram_waddr = pos_q;
			ram_wdata = val_q;
		end else begin
			ram_waddr = pos_a;
			ram_wdata = ELEM_WIDTH'(req.value);
		end
	end

	alid_ram #(
		.WIDTH (ELEM_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer. The list shape is updated as soon as a command is taken; the
	// result slot copies it once the operation on the store has finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			first_q     <= '0;
			count_q     <= '0;
			empty_q     <= 1'b1;
			status_q    <= ST_OK;
			rd_data_q   <= '0;
			ins_q       <= 1'b0;
			pos_q       <= '0;
			val_q       <= '0;
			out_valid_q <= 1'b0;
			out_rv_q    <= '0;
			out_st_q    <= ST_OK;
			out_fp_q    <= '0;
			out_len_q   <= '0;
			out_emp_q   <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						first_q   <= nxt_first;
						count_q   <= nxt_count;
						empty_q   <= nxt_empty;
						status_q  <= st_c;
						rd_data_q <= '0;
						ins_q     <= (req.cmd == CMD_INSERT);
						pos_q     <= pos_a;
						val_q     <= ELEM_WIDTH'(req.value);
						if (do_rd) begin
							state_q <= S_RDWAIT;
						end else if (do_walk) begin
							state_q <= S_WALK;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_RDWAIT: begin
					rd_data_q <= VAL_W'(ram_rdata);
					state_q   <= S_RESP;
				end
				S_WALK: begin
					if (walk_sts.last_wr) begin
						state_q <= ins_q ? S_FILL : S_RESP;
					end
				end
				S_FILL: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || rsp.ready) begin
						out_rv_q  <= rd_data_q;
						out_st_q  <= status_q;
						out_fp_q  <= POS_W'(first_q);
						out_len_q <= LEN_W'(count_q);
						out_emp_q <= empty_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// The slot refills in the same cycle that its old transaction leaves.
			if (state_q == S_RESP && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.read_value     = out_rv_q;
	assign rsp.status         = out_st_q;
	assign rsp.first_position = out_fp_q;
	assign rsp.list_length    = out_len_q;
	assign rsp.is_empty       = out_emp_q;

	// The empty flag and the length always agree.
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q == (count_q == '0))
		else $error("empty flag and length disagree");

	// An empty list sits at position zero.
	a_empty_first: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (first_q == '0))
		else $error("empty list with nonzero first position");

	// The list never runs past the end of the store.
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		end_x <= depth_x)
		else $error("list extends beyond the store");

	// No command is taken while entries are still moving.
	a_walk_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !walk_sts.busy)
		else $error("command taken during a shift");

	// The value write of an insert follows the end of its shift.
	a_fill_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> $past(walk_sts.last_wr))
		else $error("insert value written before the shift ended");

endmodule

`default_nettype wire

/* test/tb_array_list_insert_delete_unit.sv */
`default_nettype none

module tb_array_list_insert_delete_unit;
	import alid_pkg::*;

	localparam int DEPTH = DEPTH_DEF;

	// Long enough for the slowest command, which walks the whole store once.
	// This is how long we let the block run after the last expected result.
	localparam int DRAIN_CYCLES = DEPTH + 16;

	// Length of the long result-side hold-off. It is far longer than one shift
	// walk, so the block must fill its result slot and push back on the command
	// channel while the sender keeps offering work.
	localparam int HOLDOFF_CYCLES = 500;

	// One result transaction, laid out field by field as on the result channel.
	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		stat_t            status;
		logic [POS_W-1:0] first_position;
		logic [LEN_W-1:0] list_length;
		logic             is_empty;
	} list_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	alid_in_if  req_if ();
	alid_out_if rsp_if ();

	array_list_insert_delete_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Shadow copy of the list. It is updated in command-acceptance order, which
	// is also the order in which the block must return its results.
	// ------------------------------------------------------------------------
	logic [VAL_W-1:0] elem_mem [DEPTH];
	bit   [DEPTH-1:0] elem_written;      // entries that hold a defined value
	logic [POS_W-1:0] list_head;
	logic [LEN_W-1:0] list_len;
	bit               list_void;

	list_result_t pending_results [$];
	int           mismatch_count = 0;

	// Traffic shaping knobs. The sender knob is only read by the process that
	// writes it; the receiver knob is written with nonblocking assignments so the
	// receiver never races against a phase change.
	int   send_idle_pct = 0;
	int   rcv_stall_pct = 0;
	logic rsp_hold      = 1'b0;
	int   len_target    = 8;
	event holdoff_start;

	// Applies one command to the shadow list and returns the result the block
	// has to produce for it. A rejected command leaves the shadow list alone.
	function automatic list_result_t apply_command(input cmd_t op,
			input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] v);
		list_result_t r;
		int           head;
		int           tail_end;
		int           last_pos;
		head     = int'(list_head);
		tail_end = head + int'(list_len);
		r        = '0;
		r.status = ST_OK;
		case (op)
			CMD_READ: begin
				if (int'(pos) < head)
					r.status = ST_BADPOS;
				else
					r.read_value = elem_mem[pos];
			end
			CMD_WRITE: begin
				if (int'(pos) < head) begin
					r.status = ST_BADPOS;
				end else begin
					elem_mem[pos]     = v;
					elem_written[pos] = 1'b1;
				end
			end
			CMD_INSERT: begin
				if (list_void) begin
					// The first element may land anywhere and pins the head there.
					list_head         = pos;
					list_len          = 1;
					list_void         = 1'b0;
					elem_mem[pos]     = v;
					elem_written[pos] = 1'b1;
				end else if (int'(pos) < head || int'(pos) > tail_end) begin
					r.status = ST_BADPOS;
				end else if (tail_end >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (int i = tail_end; i > int'(pos); i--) begin
						elem_mem[i]     = elem_mem[i-1];
						elem_written[i] = elem_written[i-1];
					end
					elem_mem[pos]     = v;
					elem_written[pos] = 1'b1;
					list_len          = list_len + 1'b1;
				end
			end
			CMD_DELETE: begin
				last_pos = tail_end - 1;
				if (list_void || list_len == 0) begin
					r.status = ST_EMPTY;
				end else if (int'(pos) < head || int'(pos) > last_pos) begin
					r.status = ST_BADPOS;
				end else begin
					// Dropping the head only moves the head; dropping the tail only
					// shortens the list; anything in between closes the gap.
					if (int'(pos) == head) begin
						list_head = list_head + 1'b1;
					end else if (int'(pos) != last_pos) begin
						for (int i = int'(pos); i < last_pos; i++) begin
							elem_mem[i]     = elem_mem[i+1];
							elem_written[i] = elem_written[i+1];
						end
					end
					list_len = list_len - 1'b1;
					if (list_len == 0) begin
						list_head = '0;
						list_void = 1'b1;
					end
				end
			end
		endcase
		r.first_position = list_head;
		r.list_length    = list_len;
		r.is_empty       = list_void;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	function automatic logic [VAL_W-1:0] random_value();
		case ($urandom_range(15))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// A position at or above the head that holds a defined value, or -1.
	function automatic int readable_position();
		int cand [$];
		for (int i = int'(list_head); i < DEPTH; i++)
			if (elem_written[i])
				cand.push_back(i);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(cand.size() - 1)];
	endfunction

	// Builds one command against the current shadow list. Most commands are
	// legal inserts and deletes steered toward a target length, so the list
	// regularly grows long, runs into the end of the store and drains to empty.
	// The rest are reads, writes and fully random commands.
	function automatic void random_command(output cmd_t op, output logic [POS_W-1:0] pos,
			output logic [VAL_W-1:0] v);
		int roll;
		int rp;
		int ip;
		int head;
		int len;
		head = int'(list_head);
		len  = int'(list_len);
		v    = random_value();
		if (len == len_target || $urandom_range(49) == 0)
			len_target = ($urandom_range(3) == 0) ? $urandom_range(DEPTH) : $urandom_range(12);
		roll = $urandom_range(99);
		if (roll < 12) begin
			op  = cmd_t'($urandom_range(3));
			pos = POS_W'($urandom());
		end else if (roll < 22) begin
			op  = CMD_WRITE;
			pos = POS_W'($urandom_range(DEPTH - 1, head));
		end else if (roll < 34) begin
			op  = CMD_READ;
			pos = POS_W'($urandom());
		end else if ((len < len_target) == (roll < 85)) begin
			op = CMD_INSERT;
			if (list_void) begin
				pos = POS_W'($urandom());
			end else begin
				ip  = head + $urandom_range(len);
				pos = POS_W'((ip > DEPTH - 1) ? DEPTH - 1 : ip);
			end
		end else begin
			op  = CMD_DELETE;
			pos = list_void ? POS_W'($urandom()) : POS_W'(head + $urandom_range(len - 1));
		end

		// A read must never land on an entry that was never written, because the
		// store has no reset value there.
		if (op == CMD_READ && int'(pos) >= head && !elem_written[pos]) begin
			rp = readable_position();
			if (rp >= 0)
				pos = POS_W'(rp);
			else if (head > 0)
				pos = POS_W'($urandom_range(head - 1));
			else
				op = CMD_WRITE;
		end
	endfunction

	// Offers one command and waits for its transaction. The expected result is
	// computed at the accepting edge. Called and returning at a falling edge, so
	// valid is assigned at most once per time step.
	task automatic send_command(input cmd_t op, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid    <= 1'b1;
		req_if.cmd      <= op;
		req_if.position <= pos;
		req_if.value    <= v;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		pending_results.push_back(apply_command(op, pos, v));
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Result side: the receiver toggles ready at random, except while the long
	// hold-off is running. The hold-off counts its own cycles.
	// ------------------------------------------------------------------------
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	always begin
		@(holdoff_start);
		rsp_hold <= 1'b1;
		repeat (HOLDOFF_CYCLES) @(negedge clk);
		rsp_hold <= 1'b0;
	end

	function automatic void note_mismatch(input string what, input list_result_t want,
			input list_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected rd=%h st=%0d first=%0d len=%0d empty=%0b, got rd=%h st=%0d first=%0d len=%0d empty=%0b",
				$time, what, want.read_value, want.status, want.first_position,
				want.list_length, want.is_empty, got.read_value, got.status,
				got.first_position, got.list_length, got.is_empty);
	endfunction

	// Every result transaction is compared with the oldest outstanding
	// expectation, one field at a time.
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = '{rsp_if.read_value, rsp_if.status, rsp_if.first_position,
				rsp_if.list_length, rsp_if.is_empty};
			if (pending_results.size() == 0) begin
				note_mismatch("result with nothing outstanding", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.read_value !== want.read_value || got.status !== want.status ||
						got.first_position !== want.first_position ||
						got.list_length !== want.list_length ||
						got.is_empty !== want.is_empty)
					note_mismatch("result mismatch", want, got);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// Walks the corner cases by hand with no idling on either side: an empty
	// list, a list sitting at the very end of the store, a rejected full insert, inserts
	// and deletes at the head, in the middle and at the tail, rejections on
	// both sides of the list, and the list running empty again.
	task automatic test_directed();
		send_idle_pct = 0;
		rcv_stall_pct <= 0;
		send_command(CMD_DELETE, 7'd127, '0);            // delete on an empty list
		send_command(CMD_WRITE,  7'd127, 32'hFFFF_FFFF); // empty list: any position
		send_command(CMD_READ,   7'd127, '0);
		send_command(CMD_WRITE,  7'd0,   32'h0);
		send_command(CMD_READ,   7'd0,   32'hFFFF_FFFF);
		send_command(CMD_INSERT, 7'd127, 32'hA5A5_5A5A); // first element at the top
		send_command(CMD_INSERT, 7'd127, 32'h1234_5678); // no room above: full
		send_command(CMD_INSERT, 7'd126, 32'h0);         // before the head
		send_command(CMD_READ,   7'd126, '0);            // below the head
		send_command(CMD_WRITE,  7'd0,   32'h0);
		send_command(CMD_DELETE, 7'd0,   '0);
		send_command(CMD_DELETE, 7'd127, '0);            // last element goes away
		send_command(CMD_INSERT, 7'd0,   32'h0000_0001);
		send_command(CMD_INSERT, 7'd2,   32'h0000_0009); // past the tail
		send_command(CMD_INSERT, 7'd1,   32'h0000_0002); // append
		send_command(CMD_INSERT, 7'd0,   32'h0000_0003); // at the head
		send_command(CMD_INSERT, 7'd1,   32'h0000_0004); // in the middle
		send_command(CMD_READ,   7'd2,   '0);
		send_command(CMD_DELETE, 7'd2,   '0);            // middle, closes the gap
		send_command(CMD_DELETE, 7'd2,   '0);            // tail
		send_command(CMD_DELETE, 7'd5,   '0);            // beyond the tail
		send_command(CMD_DELETE, 7'd0,   '0);            // head moves up
		send_command(CMD_READ,   7'd0,   '0);
		send_command(CMD_WRITE,  7'd1,   32'hFFFF_FFFF);
		send_command(CMD_DELETE, 7'd1,   '0);
	endtask

	task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
		cmd_t             op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] v;
		send_idle_pct = idle_pct;
		rcv_stall_pct <= stall_pct;
		repeat (n) begin
			random_command(op, pos, v);
			send_command(op, pos, v);
		end
	endtask

	// The receiver holds off for a long stretch while commands keep coming
	// back to back, so the block has to stop taking commands.
	task automatic test_result_backpressure();
		cmd_t             op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] v;
		send_idle_pct = 0;
		rcv_stall_pct <= 0;
		-> holdoff_start;
		repeat (40) begin
			random_command(op, pos, v);
			send_command(op, pos, v);
		end
	endtask

	initial begin
		req_if.valid    = 1'b0;
		req_if.cmd      = CMD_READ;
		req_if.position = '0;
		req_if.value    = '0;
		elem_written    = '0;
		list_head       = '0;
		list_len        = '0;
		list_void       = 1'b1;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_traffic(240, 0, 0);
		test_random_traffic(240, 88, 0);
		test_random_traffic(240, 0, 88);
		test_random_traffic(240, 27, 27);
		test_result_backpressure();

		// Everything has been accepted; let the last results drain, then give
		// the block one full shift walk to show any stray result.
		req_if.valid <= 1'b0;
		rcv_stall_pct <= 0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: a correct run needs well under a quarter of this.
	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
